[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PITB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PITB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/pitb_pkg.sv]
// Widths, stage numbering and helpers for the point-in-triangle pipeline.
package pitb_pkg;

   localparam int FIELD_WIDTH = 16;
   localparam int COORD_WIDTH = 16;
   localparam int EXT_WIDTH   = (COORD_WIDTH > FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

   // difference of two coordinates, component product, three-term dot product
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD1_WIDTH = 2 * DIFF_WIDTH;
   localparam int DOT_WIDTH   = PROD1_WIDTH + 2;

   // split of a dot product for the wide multiply
   localparam int HALF_WIDTH  = DOT_WIDTH / 2;
   localparam int HI_WIDTH    = DOT_WIDTH - HALF_WIDTH;
   localparam int HH_WIDTH    = 2 * HI_WIDTH;
   localparam int HL_WIDTH    = HI_WIDTH + HALF_WIDTH + 1;
   localparam int LL_WIDTH    = 2 * HALF_WIDTH;
   localparam int PROD2_WIDTH = 2 * DOT_WIDTH;

   // numerators, denominator and the final sum check
   localparam int FLAG_WIDTH  = PROD2_WIDTH + 3;

   // pipeline stages
   localparam int STG_DIFF   = 0;
   localparam int STG_PROD   = 1;
   localparam int STG_DOT    = 2;
   localparam int STG_PART   = 3;
   localparam int STG_WIDE   = 4;
   localparam int STG_NUMER  = 5;
   localparam int STG_OUT    = 6;
   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic part;   // load partial products
      logic sum;    // load the combined product
   } mul_en_type;

   // keep the low COORD_WIDTH bits of a field, sign extended
   function automatic logic signed [COORD_WIDTH-1:0] sext_coord(
      input logic [FIELD_WIDTH-1:0] fld);
      logic signed [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(signed'(fld));
      return ext[COORD_WIDTH-1:0];
   endfunction

endpackage

[hw/rtl/pitb_wmul.sv]
// Two-stage signed multiplier for dot-product operands, built from partial products.
module pitb_wmul
   import pitb_pkg::*;
(
   input  logic                          clock,
   input  mul_en_type                    en,
   input  logic signed [DOT_WIDTH-1:0]   op_a,
   input  logic signed [DOT_WIDTH-1:0]   op_b,
   output logic signed [PROD2_WIDTH-1:0] prod
);

   logic signed [HI_WIDTH-1:0]     a_hi, b_hi;
   logic signed [HALF_WIDTH:0]     a_lo_s, b_lo_s;
   logic [HALF_WIDTH-1:0]          a_lo, b_lo;

   logic signed [HH_WIDTH-1:0]     hh_in, hh_ff;
   logic signed [HL_WIDTH-1:0]     hl_in, hl_ff, lh_in, lh_ff;
   logic [LL_WIDTH-1:0]            ll_in, ll_ff;
   logic signed [PROD2_WIDTH-1:0]  prod_in, prod_ff;

   assign a_hi   = signed'(op_a[DOT_WIDTH-1:HALF_WIDTH]);
   assign b_hi   = signed'(op_b[DOT_WIDTH-1:HALF_WIDTH]);
   assign a_lo   = op_a[HALF_WIDTH-1:0];
   assign b_lo   = op_b[HALF_WIDTH-1:0];
   assign a_lo_s = signed'({1'b0, a_lo});
   assign b_lo_s = signed'({1'b0, b_lo});

   always_comb begin
      hh_in = HH_WIDTH'(a_hi) * HH_WIDTH'(b_hi);
      hl_in = HL_WIDTH'(a_hi) * HL_WIDTH'(b_lo_s);
      lh_in = HL_WIDTH'(a_lo_s) * HL_WIDTH'(b_hi);
      ll_in = LL_WIDTH'(a_lo) * LL_WIDTH'(b_lo);
   end

   // exact: the full product always fits PROD2_WIDTH
   always_comb begin
      prod_in = (PROD2_WIDTH'(hh_ff) <<< (2 * HALF_WIDTH))
              + ((PROD2_WIDTH'(hl_ff) + PROD2_WIDTH'(lh_ff)) <<< HALF_WIDTH)
              + signed'(PROD2_WIDTH'(ll_ff));
   end

   always_ff @(posedge clock) begin
      if (en.part) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
      if (en.sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[hw/rtl/point_in_triangle_barycentric.sv]
// Top level: pipelined barycentric point-in-triangle test.
//
//  channel  dir  handshake           word
//  req_     in   req_valid/req_stall triangle a,b,c and query point, 12 coords
//  rsp_     out  rsp_valid/rsp_stall inside_res, degenerate
//
// One word accepted per cycle, sustained while req_stall is low; each word gives exactly one result.
// A word passes from acceptance to rsp_valid through seven register stages:
// differences, component products, dot sums, partial products of the wide
// multiplies, wide products, numerators/denominator, output flags.
// Reset clears the valid bits only; data registers carry no reset.
// A stall fills bubbles first: req_stall rises only once every stage is full.

`include "assert_macros.svh"

module point_in_triangle_barycentric
   import pitb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_a_x,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_a_y,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_a_z,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_b_x,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_b_y,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_b_z,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_c_x,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_c_y,
   input  logic signed [FIELD_WIDTH-1:0] req_vert_c_z,
   input  logic signed [FIELD_WIDTH-1:0] req_query_x,
   input  logic signed [FIELD_WIDTH-1:0] req_query_y,
   input  logic signed [FIELD_WIDTH-1:0] req_query_z,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res,
   output logic                          rsp_degenerate
);

   // ---------------------------------------------------------------- control
   // Stage k loads when it is empty or stage k+1 loads too; the output stage
   // loads when empty or when its word is being taken.
   logic [NUM_STAGES-1:0] vld_in, vld_ff;
   logic [NUM_STAGES-1:0] stg_en;

   always_comb begin
      stg_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stg_en[k] = !vld_ff[k] || stg_en[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (stg_en[STG_DIFF]) begin
         vld_in[STG_DIFF] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stg_en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !stg_en[STG_DIFF];

   // ---------------------------------------------- stage 0: edge vectors
   // e0 = c - a, e1 = b - a, dq = p - a
   logic signed [COORD_WIDTH-1:0] a_c[3], b_c[3], c_c[3], p_c[3];
   logic signed [DIFF_WIDTH-1:0]  e0_in[3], e1_in[3], dq_in[3];
   logic signed [DIFF_WIDTH-1:0]  e0_ff[3], e1_ff[3], dq_ff[3];

   always_comb begin
      a_c[0] = sext_coord(req_vert_a_x);
      a_c[1] = sext_coord(req_vert_a_y);
      a_c[2] = sext_coord(req_vert_a_z);
      b_c[0] = sext_coord(req_vert_b_x);
      b_c[1] = sext_coord(req_vert_b_y);
      b_c[2] = sext_coord(req_vert_b_z);
      c_c[0] = sext_coord(req_vert_c_x);
      c_c[1] = sext_coord(req_vert_c_y);
      c_c[2] = sext_coord(req_vert_c_z);
      p_c[0] = sext_coord(req_query_x);
      p_c[1] = sext_coord(req_query_y);
      p_c[2] = sext_coord(req_query_z);
      for (int k = 0; k < 3; k++) begin
         e0_in[k] = DIFF_WIDTH'(c_c[k]) - DIFF_WIDTH'(a_c[k]);
         e1_in[k] = DIFF_WIDTH'(b_c[k]) - DIFF_WIDTH'(a_c[k]);
         dq_in[k] = DIFF_WIDTH'(p_c[k]) - DIFF_WIDTH'(a_c[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[STG_DIFF]) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         dq_ff <= dq_in;
      end
   end

   // ------------------------------------- stage 1: component products
   logic signed [PROD1_WIDTH-1:0] p00_ff[3], p01_ff[3], p02_ff[3], p11_ff[3], p12_ff[3];

   always_ff @(posedge clock) begin
      if (stg_en[STG_PROD]) begin
         for (int k = 0; k < 3; k++) begin
            p00_ff[k] <= PROD1_WIDTH'(e0_ff[k]) * PROD1_WIDTH'(e0_ff[k]);
            p01_ff[k] <= PROD1_WIDTH'(e0_ff[k]) * PROD1_WIDTH'(e1_ff[k]);
            p02_ff[k] <= PROD1_WIDTH'(e0_ff[k]) * PROD1_WIDTH'(dq_ff[k]);
            p11_ff[k] <= PROD1_WIDTH'(e1_ff[k]) * PROD1_WIDTH'(e1_ff[k]);
            p12_ff[k] <= PROD1_WIDTH'(e1_ff[k]) * PROD1_WIDTH'(dq_ff[k]);
         end
      end
   end

   // ------------------------------------------------ stage 2: dot sums
   logic signed [DOT_WIDTH-1:0] d00_ff, d01_ff, d02_ff, d11_ff, d12_ff;

   always_ff @(posedge clock) begin
      if (stg_en[STG_DOT]) begin
         d00_ff <= DOT_WIDTH'(p00_ff[0]) + DOT_WIDTH'(p00_ff[1]) + DOT_WIDTH'(p00_ff[2]);
         d01_ff <= DOT_WIDTH'(p01_ff[0]) + DOT_WIDTH'(p01_ff[1]) + DOT_WIDTH'(p01_ff[2]);
         d02_ff <= DOT_WIDTH'(p02_ff[0]) + DOT_WIDTH'(p02_ff[1]) + DOT_WIDTH'(p02_ff[2]);
         d11_ff <= DOT_WIDTH'(p11_ff[0]) + DOT_WIDTH'(p11_ff[1]) + DOT_WIDTH'(p11_ff[2]);
         d12_ff <= DOT_WIDTH'(p12_ff[0]) + DOT_WIDTH'(p12_ff[1]) + DOT_WIDTH'(p12_ff[2]);
      end
   end

   // ------------------------------- stages 3 and 4: six wide products
   // den = d00*d11 - d01*d01, U = d11*d02 - d01*d12, V = d00*d12 - d01*d02
   mul_en_type                    mul_en;
   logic signed [PROD2_WIDTH-1:0] m_den_a, m_den_b, m_un_a, m_un_b, m_vn_a, m_vn_b;

   assign mul_en.part = stg_en[STG_PART];
   assign mul_en.sum  = stg_en[STG_WIDE];

   pitb_wmul u_mul_den_a (.clock(clock), .en(mul_en), .op_a(d00_ff), .op_b(d11_ff),
                          .prod(m_den_a));
   pitb_wmul u_mul_den_b (.clock(clock), .en(mul_en), .op_a(d01_ff), .op_b(d01_ff),
                          .prod(m_den_b));
   pitb_wmul u_mul_un_a  (.clock(clock), .en(mul_en), .op_a(d11_ff), .op_b(d02_ff),
                          .prod(m_un_a));
   pitb_wmul u_mul_un_b  (.clock(clock), .en(mul_en), .op_a(d01_ff), .op_b(d12_ff),
                          .prod(m_un_b));
   pitb_wmul u_mul_vn_a  (.clock(clock), .en(mul_en), .op_a(d00_ff), .op_b(d12_ff),
                          .prod(m_vn_a));
   pitb_wmul u_mul_vn_b  (.clock(clock), .en(mul_en), .op_a(d01_ff), .op_b(d02_ff),
                          .prod(m_vn_b));

   // ------------------------------ stage 5: numerators and denominator
   logic signed [FLAG_WIDTH-1:0] den_ff, un_ff, vn_ff;

   always_ff @(posedge clock) begin
      if (stg_en[STG_NUMER]) begin
         den_ff <= FLAG_WIDTH'(m_den_a) - FLAG_WIDTH'(m_den_b);
         un_ff  <= FLAG_WIDTH'(m_un_a) - FLAG_WIDTH'(m_un_b);
         vn_ff  <= FLAG_WIDTH'(m_vn_a) - FLAG_WIDTH'(m_vn_b);
      end
   end

   // -------------------------------------------- stage 6: output flags
   // inside when den > 0, U >= 0, V >= 0 and U + V < den
   logic signed [FLAG_WIDTH-1:0] slack;
   logic                         degen_in, inside_in;
   logic                         rsp_inside_ff, rsp_degen_ff;

   always_comb begin
      slack     = un_ff + vn_ff - den_ff;
      degen_in  = den_ff[FLAG_WIDTH-1] || (den_ff == '0);
      inside_in = !degen_in && !un_ff[FLAG_WIDTH-1] && !vn_ff[FLAG_WIDTH-1]
                  && slack[FLAG_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (stg_en[STG_OUT]) begin
         rsp_inside_ff <= inside_in;
         rsp_degen_ff  <= degen_in;
      end
   end

   assign rsp_valid      = vld_ff[STG_OUT];
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_degenerate = rsp_degen_ff;

   // ------------------------------------------------------------ checks
   `PITB_ASSERT_NOW(a_degen_not_inside, rsp_valid, !(rsp_inside_res && rsp_degenerate),
                    "degenerate triangle reported inside")
   `PITB_ASSERT_NOW(a_stall_only_when_full, req_stall, vld_ff == '1,
                    "input stalled while a stage is empty")
   `PITB_ASSERT_NEXT(a_held_word_kept, vld_ff[STG_NUMER] && rsp_valid && rsp_stall,
                     vld_ff[STG_NUMER] && rsp_valid, "word lost behind a stalled output")
   `PITB_ASSERT_NOW(a_reset_empties, $past(reset), vld_ff == '0,
                    "pipeline not empty after reset")

endmodule
